// ----- sv/qtr_pkg.sv -----
`timescale 1ns / 1ps
// shared constants and types of the quaternion to rotation matrix pipeline
package qtr_pkg;

	localparam int IN_W   = 32;
	localparam int OUT_W  = 32;
	localparam int PROD_W = 2 * IN_W;
	localparam int NUM_W  = PROD_W + 2;
	localparam int MAG_W  = PROD_W + 1;
	localparam int REM_W  = MAG_W + 1;
	localparam int Q_W    = OUT_W;
	localparam int N_ENT  = 9;
	localparam int N_PROD = 10;

	localparam logic [OUT_W-1:0] ONE_Q30   = 32'h4000_0000;
	localparam logic [N_ENT-1:0] DIAG_MASK = 9'b1_0001_0001;

	typedef struct packed {
		logic                             valid;
		logic                             degen;
		logic [MAG_W-1:0]                 den;
		logic [N_ENT-1:0][MAG_W-1:0]      num;
		logic [N_ENT-1:0]                 neg;
	} div_in_t;

	typedef struct packed {
		logic                             valid;
		logic                             degen;
		logic [N_ENT-1:0][Q_W-1:0]        quo;
		logic [N_ENT-1:0]                 neg;
	} div_out_t;

endpackage

// ----- sv/qtr_quat_if.sv -----
`timescale 1ns / 1ps
// quaternion input channel
interface qtr_quat_if import qtr_pkg::*; ();

	logic                    valid;
	logic                    ready;
	logic signed [IN_W-1:0]  quat_x;
	logic signed [IN_W-1:0]  quat_y;
	logic signed [IN_W-1:0]  quat_z;
	logic signed [IN_W-1:0]  quat_w;

	modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
	modport sink (input valid, quat_x, quat_y, quat_z, quat_w, output ready);

endinterface

// ----- sv/qtr_mat_if.sv -----
`timescale 1ns / 1ps
// rotation matrix output channel
interface qtr_mat_if import qtr_pkg::*; ();

	logic                     valid;
	logic                     ready;
	logic signed [OUT_W-1:0]  m00;
	logic signed [OUT_W-1:0]  m01;
	logic signed [OUT_W-1:0]  m02;
	logic signed [OUT_W-1:0]  m10;
	logic signed [OUT_W-1:0]  m11;
	logic signed [OUT_W-1:0]  m12;
	logic signed [OUT_W-1:0]  m20;
	logic signed [OUT_W-1:0]  m21;
	logic signed [OUT_W-1:0]  m22;
	logic                     degenerate;

	modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate,
		input ready);
	modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate,
		output ready);

endinterface

// ----- sv/qtr_div_pipe.sv -----
`timescale 1ns / 1ps
// nine-lane pipelined restoring divider, one quotient bit per stage
module qtr_div_pipe import qtr_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     en,
	input  div_in_t  din,
	output div_out_t dout
);

	typedef struct packed {
		logic                        degen;
		logic [MAG_W-1:0]            den;
		logic [N_ENT-1:0][REM_W-1:0] rem;
		logic [N_ENT-1:0][Q_W-1:0]   quo;
		logic [N_ENT-1:0]            neg;
	} step_t;

	step_t       first;
	step_t       cur [Q_W];
	step_t       nxt [Q_W];
	step_t       step_s [1:Q_W];
	logic [Q_W:1] valid_s;

	always_comb begin
		first.degen = din.degen;
		first.den   = din.den;
		first.neg   = din.neg;
		for (int e = 0; e < N_ENT; e++) begin
			first.rem[e] = REM_W'(din.num[e]);
			first.quo[e] = '0;
		end
	end

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [N_ENT-1:0]            ge;
		logic [N_ENT-1:0][REM_W-1:0] diff;

		if (k == 0) begin : g_first
			assign cur[k] = first;
		end else begin : g_mid
			assign cur[k] = step_s[k];
		end

		always_comb begin
			nxt[k] = cur[k];
			for (int e = 0; e < N_ENT; e++) begin
				diff[e] = cur[k].rem[e] - REM_W'(cur[k].den);
				ge[e]   = cur[k].rem[e] >= REM_W'(cur[k].den);
				nxt[k].rem[e] = ge[e] ? {diff[e][REM_W-2:0], 1'b0}
					: {cur[k].rem[e][REM_W-2:0], 1'b0};
				nxt[k].quo[e] = {cur[k].quo[e][Q_W-2:0], ge[e]};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				step_s[k+1] <= nxt[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= '0;
		end else if (en) begin
			valid_s <= {valid_s[Q_W-1:1], din.valid};
		end
	end

	assign dout.valid = valid_s[Q_W];
	assign dout.degen = step_s[Q_W].degen;
	assign dout.quo   = step_s[Q_W].quo;
	assign dout.neg   = step_s[Q_W].neg;

endmodule

// ----- sv/quaternion_to_rotation_matrix.sv -----
`timescale 1ns / 1ps
// throughput: one item per cycle when not stalled; products, sums, magnitudes, 32 divider
// stages of one quotient bit each and a rounding stage advance together
// a stalled output holds the whole pipeline; nothing is lost or repeated
// reset clears the valid bits only, payload registers are not reset
module quaternion_to_rotation_matrix import qtr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	qtr_quat_if.sink      quat,
	qtr_mat_if.source     mat
);

	localparam int P_XX = 0;
	localparam int P_YY = 1;
	localparam int P_ZZ = 2;
	localparam int P_WW = 3;
	localparam int P_XY = 4;
	localparam int P_XZ = 5;
	localparam int P_YZ = 6;
	localparam int P_XW = 7;
	localparam int P_YW = 8;
	localparam int P_ZW = 9;

	localparam int E00 = 0;
	localparam int E01 = 1;
	localparam int E02 = 2;
	localparam int E10 = 3;
	localparam int E11 = 4;
	localparam int E12 = 5;
	localparam int E20 = 6;
	localparam int E21 = 7;
	localparam int E22 = 8;

	function automatic logic signed [NUM_W-1:0] ext(input logic signed [PROD_W-1:0] p);
		return NUM_W'(p);
	endfunction

	logic                           en;
	logic                           valid_s1;
	logic                           valid_s2;
	logic                           valid_s3;
	logic signed [PROD_W-1:0]       prod_s1 [N_PROD];
	logic signed [NUM_W-1:0]        num_s2 [N_ENT];
	logic [MAG_W-1:0]               norm_s2;
	logic [N_ENT-1:0][MAG_W-1:0]    num_s3;
	logic [N_ENT-1:0]               neg_s3;
	logic [MAG_W-1:0]               den_s3;
	logic                           degen_s3;
	logic [NUM_W-1:0]               mag [N_ENT];
	logic [N_ENT-1:0][MAG_W-1:0]    num_nxt;
	div_in_t                        din;
	div_out_t                       dout;
	logic [OUT_W-1:0]               rnd [N_ENT];
	logic [OUT_W-1:0]               ent_nxt [N_ENT];
	logic [OUT_W-1:0]               res_q [N_ENT];
	logic                           degen_q;
	logic                           res_valid_q;

	assign en         = !res_valid_q || mat.ready;
	assign quat.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			valid_s1    <= quat.valid;
			valid_s2    <= valid_s1;
			valid_s3    <= valid_s2;
			res_valid_q <= dout.valid;
		end
	end

	// products
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1[P_XX] <= PROD_W'(quat.quat_x) * PROD_W'(quat.quat_x);
			prod_s1[P_YY] <= PROD_W'(quat.quat_y) * PROD_W'(quat.quat_y);
			prod_s1[P_ZZ] <= PROD_W'(quat.quat_z) * PROD_W'(quat.quat_z);
			prod_s1[P_WW] <= PROD_W'(quat.quat_w) * PROD_W'(quat.quat_w);
			prod_s1[P_XY] <= PROD_W'(quat.quat_x) * PROD_W'(quat.quat_y);
			prod_s1[P_XZ] <= PROD_W'(quat.quat_x) * PROD_W'(quat.quat_z);
			prod_s1[P_YZ] <= PROD_W'(quat.quat_y) * PROD_W'(quat.quat_z);
			prod_s1[P_XW] <= PROD_W'(quat.quat_x) * PROD_W'(quat.quat_w);
			prod_s1[P_YW] <= PROD_W'(quat.quat_y) * PROD_W'(quat.quat_w);
			prod_s1[P_ZW] <= PROD_W'(quat.quat_z) * PROD_W'(quat.quat_w);
		end
	end

	// norm and signed numerators
	always_ff @(posedge clk) begin
		if (en) begin
			norm_s2 <= MAG_W'(prod_s1[P_XX]) + MAG_W'(prod_s1[P_YY])
				+ MAG_W'(prod_s1[P_ZZ]) + MAG_W'(prod_s1[P_WW]);
			num_s2[E00] <= ext(prod_s1[P_WW]) + ext(prod_s1[P_XX])
				- ext(prod_s1[P_YY]) - ext(prod_s1[P_ZZ]);
			num_s2[E11] <= ext(prod_s1[P_WW]) + ext(prod_s1[P_YY])
				- ext(prod_s1[P_XX]) - ext(prod_s1[P_ZZ]);
			num_s2[E22] <= ext(prod_s1[P_WW]) + ext(prod_s1[P_ZZ])
				- ext(prod_s1[P_XX]) - ext(prod_s1[P_YY]);
			num_s2[E01] <= ext(prod_s1[P_XY]) - ext(prod_s1[P_ZW]);
			num_s2[E02] <= ext(prod_s1[P_XZ]) + ext(prod_s1[P_YW]);
			num_s2[E10] <= ext(prod_s1[P_XY]) + ext(prod_s1[P_ZW]);
			num_s2[E12] <= ext(prod_s1[P_YZ]) - ext(prod_s1[P_XW]);
			num_s2[E20] <= ext(prod_s1[P_XZ]) - ext(prod_s1[P_YW]);
			num_s2[E21] <= ext(prod_s1[P_YZ]) + ext(prod_s1[P_XW]);
		end
	end

	// magnitudes, off-diagonal terms doubled
	always_comb begin
		for (int e = 0; e < N_ENT; e++) begin
			mag[e] = num_s2[e][NUM_W-1] ? NUM_W'(-num_s2[e]) : NUM_W'(num_s2[e]);
			num_nxt[e] = DIAG_MASK[e] ? mag[e][MAG_W-1:0] : {mag[e][MAG_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3   <= num_nxt;
			for (int e = 0; e < N_ENT; e++) begin
				neg_s3[e] <= num_s2[e][NUM_W-1];
			end
			den_s3   <= norm_s2;
			degen_s3 <= norm_s2 == '0;
		end
	end

	assign din.valid = valid_s3;
	assign din.degen = degen_s3;
	assign din.den   = den_s3;
	assign din.num   = num_s3;
	assign din.neg   = neg_s3;

	qtr_div_pipe u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.din    (din),
		.dout   (dout)
	);

	// round half away from zero, identity on zero norm
	always_comb begin
		for (int e = 0; e < N_ENT; e++) begin
			rnd[e] = OUT_W'((OUT_W'(1) + (OUT_W + 1)'(dout.quo[e])) >> 1);
			if (dout.degen) begin
				ent_nxt[e] = DIAG_MASK[e] ? ONE_Q30 : '0;
			end else begin
				ent_nxt[e] = dout.neg[e] ? OUT_W'(-rnd[e]) : rnd[e];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q   <= ent_nxt;
			degen_q <= dout.degen;
		end
	end

	assign mat.valid      = res_valid_q;
	assign mat.m00        = res_q[E00];
	assign mat.m01        = res_q[E01];
	assign mat.m02        = res_q[E02];
	assign mat.m10        = res_q[E10];
	assign mat.m11        = res_q[E11];
	assign mat.m12        = res_q[E12];
	assign mat.m20        = res_q[E20];
	assign mat.m21        = res_q[E21];
	assign mat.m22        = res_q[E22];
	assign mat.degenerate = degen_q;

endmodule

// ----- sv/qtr_chk.sv -----
`timescale 1ns / 1ps
// port-level checker for the quaternion to rotation matrix block, with bind
module qtr_chk import qtr_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic signed [OUT_W-1:0] m00,
	input logic signed [OUT_W-1:0] m01,
	input logic signed [OUT_W-1:0] m02,
	input logic signed [OUT_W-1:0] m10,
	input logic signed [OUT_W-1:0] m11,
	input logic signed [OUT_W-1:0] m12,
	input logic signed [OUT_W-1:0] m20,
	input logic signed [OUT_W-1:0] m21,
	input logic signed [OUT_W-1:0] m22,
	input logic                    degenerate
);

	localparam logic signed [OUT_W-1:0] ONE_P = ONE_Q30;
	localparam logic signed [OUT_W-1:0] ONE_N = -ONE_Q30;

	// stalled item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid
			&& $stable({m00, m01, m02, m10, m11, m12, m20, m21, m22, degenerate}))
		else $error("output item changed while stalled");

	// empty output stage never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	// full, stalled output blocks the input
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while output stalled");

	// zero norm gives identity
	a_identity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> m00 == ONE_P && m11 == ONE_P && m22 == ONE_P
			&& m01 == 0 && m02 == 0 && m10 == 0 && m12 == 0 && m20 == 0 && m21 == 0)
		else $error("degenerate item is not the identity");

	// rotation entries stay within [-1, 1]
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> m00 <= ONE_P && m00 >= ONE_N && m01 <= ONE_P && m01 >= ONE_N
			&& m02 <= ONE_P && m02 >= ONE_N && m10 <= ONE_P && m10 >= ONE_N
			&& m11 <= ONE_P && m11 >= ONE_N && m12 <= ONE_P && m12 >= ONE_N
			&& m20 <= ONE_P && m20 >= ONE_N && m21 <= ONE_P && m21 >= ONE_N
			&& m22 <= ONE_P && m22 >= ONE_N)
		else $error("matrix entry out of range");

endmodule

bind quaternion_to_rotation_matrix qtr_chk u_qtr_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (quat.ready),
	.out_valid  (mat.valid),
	.out_ready  (mat.ready),
	.m00        (mat.m00),
	.m01        (mat.m01),
	.m02        (mat.m02),
	.m10        (mat.m10),
	.m11        (mat.m11),
	.m12        (mat.m12),
	.m20        (mat.m20),
	.m21        (mat.m21),
	.m22        (mat.m22),
	.degenerate (mat.degenerate)
);
